### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### src/ehp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header parser package
// Types, constants and codes shared by the header parser modules.
// ---------------------------------------------------------------------------
package ehp_pkg;

   localparam int LENGTH_COUNTER_BITS_DEF = 14;
   localparam int LEN_W                   = 14;
   localparam logic [LEN_W-1:0] LEN_MAX   = '1;

   localparam logic [15:0] TYPE_IPV4  = 16'h0800;
   localparam logic [15:0] TYPE_IPV6  = 16'h86DD;
   localparam logic [15:0] TYPE_QTAG  = 16'h8100;
   localparam logic [15:0] TYPE_ADTAG = 16'h88A8;

   localparam int ETH_HDR_LEN  = 14;
   localparam int VLAN_TAG_LEN = 4;
   localparam int ETYPE_OFS    = ETH_HDR_LEN - 2;
   localparam int V4_MIN_HDR   = 20;
   localparam int V6_HDR_LEN   = 40;
   localparam int L4_PORT_END  = 4;

   localparam logic [7:0] IHL_MASK = 8'h0f;
   localparam logic [3:0] IP_VER4  = 4'd4;
   localparam logic [3:0] IP_VER6  = 4'd6;

   localparam int NS_W = 5;
   localparam logic [NS_W-1:0] NET_START_0 = NS_W'(ETH_HDR_LEN);
   localparam logic [NS_W-1:0] NET_START_1 = NS_W'(ETH_HDR_LEN + VLAN_TAG_LEN);
   localparam logic [NS_W-1:0] NET_START_2 = NS_W'(ETH_HDR_LEN + 2 * VLAN_TAG_LEN);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_IPV6_ENABLE = 1'b0;
   localparam logic REG_LENGTH_CAP  = 1'b1;
   localparam logic [LEN_W-1:0] LENGTH_CAP_RESET = LEN_W'(9000);

   typedef enum logic [1:0] {
      CLASS_PASS      = 2'd0,
      CLASS_MALFORMED = 2'd1,
      CLASS_IPV4      = 2'd2,
      CLASS_IPV6      = 2'd3
   } class_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      class_type   frame_class;
      logic [31:0] source_v4;
      logic [63:0] source_v6_upper;
      logic [63:0] source_v6_lower;
      logic [7:0]  protocol_number;
      logic [15:0] destination_port;
      logic [13:0] frame_length;
   } rsp_item_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [1:0]       tag_count;
      logic [15:0]      ethertype;
      logic [NS_W-1:0]  net_start;
      logic [5:0]       header_bytes;
      logic [7:0]       first_byte;
      logic [31:0]      v4_source;
      logic [7:0]       protocol;
      logic [15:0]      port;
      logic [63:0]      v6_upper;
      logic [63:0]      v6_lower;
   } summary_type;

endpackage

### src/ehp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header parser front end
// Walks frame bytes, skips VLAN tags, captures header fields, emits a summary.
// ---------------------------------------------------------------------------
module ehp_front #(
   parameter int LENGTH_COUNTER_BITS = ehp_pkg::LENGTH_COUNTER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_take,
   input  ehp_pkg::req_item_type in_item,
   output logic                 sum_push,
   output ehp_pkg::summary_type sum_item
);
   import ehp_pkg::*;

   localparam int CW = LENGTH_COUNTER_BITS;
   localparam logic [CW-1:0] COUNT_MAX = '1;
   localparam logic [CW-1:0] ET_A0 = CW'(ETYPE_OFS);
   localparam logic [CW-1:0] ET_A1 = CW'(ETYPE_OFS + 1);
   localparam logic [CW-1:0] ET_B0 = CW'(ETYPE_OFS + VLAN_TAG_LEN);
   localparam logic [CW-1:0] ET_B1 = CW'(ETYPE_OFS + VLAN_TAG_LEN + 1);
   localparam logic [CW-1:0] ET_C0 = CW'(ETYPE_OFS + 2 * VLAN_TAG_LEN);
   localparam logic [CW-1:0] ET_C1 = CW'(ETYPE_OFS + 2 * VLAN_TAG_LEN + 1);
   localparam logic [CW-1:0] V4_PROTO  = CW'(9);
   localparam logic [CW-1:0] V4_SRC_LO = CW'(12);
   localparam logic [CW-1:0] V4_SRC_HI = CW'(15);
   localparam logic [CW-1:0] V6_NH     = CW'(6);
   localparam logic [CW-1:0] V6_UP_LO  = CW'(8);
   localparam logic [CW-1:0] V6_UP_HI  = CW'(15);
   localparam logic [CW-1:0] V6_LO_LO  = CW'(16);
   localparam logic [CW-1:0] V6_LO_HI  = CW'(23);

   logic [CW-1:0]   pos_ff, pos_in;
   logic [15:0]     et_ff, et_in;
   logic [1:0]      tag_ff, tag_in;
   logic [NS_W-1:0] ns_ff, ns_in;
   logic [5:0]      hb_ff, hb_in;
   logic [7:0]      fhb_ff, fhb_in;
   logic [31:0]     v4_ff, v4_in;
   logic [7:0]      proto_ff, proto_in;
   logic [15:0]     port_ff, port_in;
   logic [63:0]     v6u_ff, v6u_in;
   logic [63:0]     v6l_ff, v6l_in;

   logic [CW-1:0] idx, cnt, rel;
   logic [7:0]    b;
   logic          et_take, in_net;

   always_comb begin
      idx = pos_ff;
      b   = in_item.frame_byte;
      cnt = (idx < COUNT_MAX) ? idx + CW'(1) : COUNT_MAX;

      et_take = (idx == ET_A0) || (idx == ET_A1) ||
                (((idx == ET_B0) || (idx == ET_B1)) && (tag_ff != 2'd0)) ||
                (((idx == ET_C0) || (idx == ET_C1)) && (tag_ff == 2'd2));
      et_in  = et_take ? {et_ff[7:0], b} : et_ff;
      tag_in = tag_ff;
      ns_in  = ns_ff;
      if ((idx == ET_A1) && ((et_in == TYPE_QTAG) || (et_in == TYPE_ADTAG))) begin
         tag_in = 2'd1;
         ns_in  = NET_START_1;
      end else if ((idx == ET_B1) && (tag_ff == 2'd1) && (et_in == TYPE_QTAG)) begin
         tag_in = 2'd2;
         ns_in  = NET_START_2;
      end

      in_net   = idx >= CW'(ns_in);
      rel      = idx - CW'(ns_in);
      hb_in    = hb_ff;
      fhb_in   = fhb_ff;
      v4_in    = v4_ff;
      proto_in = proto_ff;
      port_in  = port_ff;
      v6u_in   = v6u_ff;
      v6l_in   = v6l_ff;
      if (in_net) begin
         if (rel == '0) begin
            fhb_in = b;
            hb_in  = 6'({b & IHL_MASK, 2'b00});
         end
         if (et_in == TYPE_IPV4) begin
            if (rel == V4_PROTO) proto_in = b;
            if ((rel >= V4_SRC_LO) && (rel <= V4_SRC_HI)) v4_in = {v4_ff[23:0], b};
            if ((rel == CW'(hb_ff) + CW'(2)) || (rel == CW'(hb_ff) + CW'(3)))
               port_in = {port_ff[7:0], b};
         end else if (et_in == TYPE_IPV6) begin
            if (rel == V6_NH) proto_in = b;
            if ((rel >= V6_UP_LO) && (rel <= V6_UP_HI)) v6u_in = {v6u_ff[55:0], b};
            if ((rel >= V6_LO_LO) && (rel <= V6_LO_HI)) v6l_in = {v6l_ff[55:0], b};
         end
      end

      sum_push              = in_take && in_item.last_byte;
      sum_item.length       = (cnt > CW'(LEN_MAX)) ? LEN_MAX : cnt[LEN_W-1:0];
      sum_item.tag_count    = tag_in;
      sum_item.ethertype    = et_in;
      sum_item.net_start    = ns_in;
      sum_item.header_bytes = hb_in;
      sum_item.first_byte   = fhb_in;
      sum_item.v4_source    = v4_in;
      sum_item.protocol     = proto_in;
      sum_item.port         = port_in;
      sum_item.v6_upper     = v6u_in;
      sum_item.v6_lower     = v6l_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (in_take && in_item.last_byte)) begin
         pos_ff   <= '0;
         et_ff    <= '0;
         tag_ff   <= '0;
         ns_ff    <= NET_START_0;
         hb_ff    <= '0;
         fhb_ff   <= '0;
         v4_ff    <= '0;
         proto_ff <= '0;
         port_ff  <= '0;
         v6u_ff   <= '0;
         v6l_ff   <= '0;
      end else if (in_take) begin
         pos_ff   <= cnt;
         et_ff    <= et_in;
         tag_ff   <= tag_in;
         ns_ff    <= ns_in;
         hb_ff    <= hb_in;
         fhb_ff   <= fhb_in;
         v4_ff    <= v4_in;
         proto_ff <= proto_in;
         port_ff  <= port_in;
         v6u_ff   <= v6u_in;
         v6l_ff   <= v6l_in;
      end
   end

endmodule

### src/ehp_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Summary queue
// Short queue of frame summaries between the front and back ends.
// ---------------------------------------------------------------------------
module ehp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  ehp_pkg::summary_type wr_item,
   output logic                 q_full,
   input  logic                 rd_en,
   output logic                 q_empty,
   output ehp_pkg::summary_type rd_item
);
   import ehp_pkg::*;

   summary_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_wr, do_rd;

   always_comb begin
      q_full   = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
      q_empty  = count_ff == '0;
      do_wr    = wr_en && !q_full;
      do_rd    = rd_en && !q_empty;
      rd_item  = slot_ff[rptr_ff];
      wptr_in  = (wptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      rptr_in  = (rptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      count_in = count_ff + QUEUE_CNT_W'(do_wr) - QUEUE_CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= wptr_in;
         if (do_rd) rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count over depth")
   `ASSERT_NEXT(a_count_up, clock, reset, do_wr && !do_rd, count_ff == $past(count_ff) + 1'b1, "queue count did not advance")
   `ASSERT_NEXT(a_count_down, clock, reset, do_rd && !do_wr, count_ff == $past(count_ff) - 1'b1, "queue count did not drop")

endmodule

### src/ehp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header parser back end
// Classifies a frame summary and holds the result until it is taken.
// ---------------------------------------------------------------------------
module ehp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  ehp_pkg::summary_type        sum_item,
   output logic                        q_rd,
   input  logic                        ipv6_enable,
   input  logic [ehp_pkg::LEN_W-1:0]   length_cap,
   input  logic                        out_pop,
   output logic                        out_empty,
   output ehp_pkg::rsp_item_type       out_item
);
   import ehp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type res_ff, res_in;
   logic         load;
   logic [6:0]   ns7, v4_min, hdr_end, l4_end, v6_min;
   logic [LEN_W-1:0] n;

   always_comb begin
      n       = sum_item.length;
      ns7     = 7'(sum_item.net_start);
      v4_min  = ns7 + 7'(V4_MIN_HDR);
      hdr_end = ns7 + 7'(sum_item.header_bytes);
      l4_end  = hdr_end + 7'(L4_PORT_END);
      v6_min  = ns7 + 7'(V6_HDR_LEN);

      res_in                  = '0;
      res_in.frame_class      = CLASS_PASS;
      res_in.frame_length     = (n < length_cap) ? n : length_cap;
      priority if (n < LEN_W'(ETH_HDR_LEN)) begin
         res_in.frame_class = CLASS_PASS;
      end else if ((sum_item.tag_count != 2'd0) && (n < LEN_W'(NET_START_1))) begin
         res_in.frame_class = CLASS_MALFORMED;
      end else if ((sum_item.tag_count == 2'd2) && (n < LEN_W'(NET_START_2))) begin
         res_in.frame_class = CLASS_MALFORMED;
      end else if (sum_item.ethertype == TYPE_IPV4) begin
         if ((n < LEN_W'(v4_min)) || (sum_item.first_byte[7:4] != IP_VER4) ||
             (sum_item.header_bytes < 6'(V4_MIN_HDR)) || (n < LEN_W'(hdr_end))) begin
            res_in.frame_class = CLASS_MALFORMED;
         end else begin
            res_in.frame_class     = CLASS_IPV4;
            res_in.source_v4       = sum_item.v4_source;
            res_in.protocol_number = sum_item.protocol;
            if (n >= LEN_W'(l4_end)) res_in.destination_port = sum_item.port;
         end
      end else if ((sum_item.ethertype == TYPE_IPV6) && ipv6_enable) begin
         if ((n < LEN_W'(v6_min)) || (sum_item.first_byte[7:4] != IP_VER6)) begin
            res_in.frame_class = CLASS_MALFORMED;
         end else begin
            res_in.frame_class     = CLASS_IPV6;
            res_in.source_v6_upper = sum_item.v6_upper;
            res_in.source_v6_lower = sum_item.v6_lower;
            res_in.protocol_number = sum_item.protocol;
         end
      end else begin
         res_in.frame_class = CLASS_PASS;
      end

      load      = !valid_ff || out_pop;
      q_rd      = load && !q_empty;
      valid_in  = q_rd ? 1'b1 : (out_pop ? 1'b0 : valid_ff);
      out_empty = !valid_ff;
      out_item  = res_ff;
   end

   always_ff @(posedge clock) begin
      if (q_rd) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

### src/ethernet_ip_header_parser_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ethernet IP header parser
// Parses Ethernet, VLAN, IPv4 and IPv6 headers and reports one result per frame.
// ---------------------------------------------------------------------------
// Throughput: one frame byte per cycle while the queue is not full, set by the front end's per-byte capture.
// Result path: the summary is written into the queue when the last byte is taken, then
//   loads the result register once that register is free.
// Reset: synchronous; clears frame state, queue and result valid flag, loads register defaults.
module ethernet_ip_header_parser_unit #(
   parameter int LENGTH_COUNTER_BITS = ehp_pkg::LENGTH_COUNTER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  ehp_pkg::req_item_type             req_item,
   output logic                              empty,
   input  logic                              pop,
   output ehp_pkg::rsp_item_type             rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ehp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ehp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ehp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import ehp_pkg::*;

   logic             ipv6_en_ff, ipv6_en_in;
   logic [LEN_W-1:0] cap_ff, cap_in;
   logic             csr_wr, in_take, sum_push, q_full, q_empty, q_rd;
   summary_type      sum_item, head_item;

   always_comb begin
      pready     = 1'b1;
      csr_wr     = psel && penable && pwrite && pready;
      ipv6_en_in = ipv6_en_ff;
      cap_in     = cap_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_IPV6_ENABLE: ipv6_en_in = pwdata[0];
            REG_LENGTH_CAP:  cap_in     = pwdata[LEN_W-1:0];
            default:         cap_in     = cap_ff;
         endcase
      end
      unique case (paddr[2])
         REG_IPV6_ENABLE: prdata = CSR_DATA_W'(ipv6_en_ff);
         REG_LENGTH_CAP:  prdata = CSR_DATA_W'(cap_ff);
         default:         prdata = '0;
      endcase
      full    = q_full;
      in_take = push && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv6_en_ff <= 1'b1;
         cap_ff     <= LENGTH_CAP_RESET;
      end else begin
         ipv6_en_ff <= ipv6_en_in;
         cap_ff     <= cap_in;
      end
   end

   ehp_front #(
      .LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_take  (in_take),
      .in_item  (req_item),
      .sum_push (sum_push),
      .sum_item (sum_item)
   );

   ehp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (sum_push),
      .wr_item (sum_item),
      .q_full  (q_full),
      .rd_en   (q_rd),
      .q_empty (q_empty),
      .rd_item (head_item)
   );

   ehp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .sum_item    (head_item),
      .q_rd        (q_rd),
      .ipv6_enable (ipv6_en_ff),
      .length_cap  (cap_ff),
      .out_pop     (pop),
      .out_empty   (empty),
      .out_item    (rsp_item)
   );

endmodule
